[design/runs_up_down_tally_top_defines.svh]
// Assertion macros shared by the checker of the runs up and down tally.
`ifndef RUNS_UP_DOWN_TALLY_TOP_DEFINES_SVH
`define RUNS_UP_DOWN_TALLY_TOP_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define RUDT_ASSERT_NOW(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("runs tally check failed");

// The condition must hold in the cycle after the trigger.
`define RUDT_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("runs tally check failed");

`endif

[design/rudt_pkg.sv]
// Package with the types, constants and helper functions of the runs tally.
`timescale 1ns / 1ps
package rudt_pkg;

    localparam int MAX_RUN_BINS = 32;
    localparam int SAMPLE_BITS  = 32;
    localparam int BIN_AW       = $clog2(MAX_RUN_BINS);
    localparam int CNT_W        = 32;
    localparam int SUM_W        = 40;
    localparam int IDX_W        = 5;
    localparam int LEN_OUT_W    = 5;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QAW          = $clog2(QUEUE_DEPTH);

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [BIN_AW-1:0]      t_bin;
    typedef logic [CNT_W-1:0]       t_count;
    typedef logic [SUM_W-1:0]       t_sum;
    typedef logic [IDX_W-1:0]       t_idx;
    typedef logic [LEN_OUT_W-1:0]   t_len_out;

    localparam t_bin TOP_BIN = t_bin'(MAX_RUN_BINS - 1);

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef struct packed {
        logic close_valid;
        logic close_up;
        t_bin close_len;
        logic report_ok;
        t_bin report_bin;
        t_bin cur_len;
        logic cur_rising;
    } t_event;

    function automatic t_count sat_inc_count(input t_count v);
        return (v == '1) ? v : v + t_count'(1);
    endfunction

    function automatic t_sum sat_add_sum(input t_sum v, input t_bin len);
        logic [SUM_W:0] s;
        s = {1'b0, v} + (SUM_W + 1)'(len);
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

endpackage

[design/rudt_if.sv]
// Channel interfaces for the input and result transactions of the runs tally.
`timescale 1ns / 1ps
interface rudt_in_if;
    logic            valid;
    logic            ready;
    logic            operation;
    logic [31:0]     sample;
    rudt_pkg::t_idx  bin_index;

    modport source (output valid, output operation, output sample, output bin_index,
                    input ready);
    modport sink   (input valid, input operation, input sample, input bin_index,
                    output ready);
endinterface

interface rudt_out_if;
    logic               valid;
    logic               ready;
    rudt_pkg::t_count   up_bin_count;
    rudt_pkg::t_count   down_bin_count;
    rudt_pkg::t_count   up_run_total;
    rudt_pkg::t_count   down_run_total;
    rudt_pkg::t_sum     up_length_sum;
    rudt_pkg::t_sum     down_length_sum;
    rudt_pkg::t_len_out current_length;
    logic               current_rising;

    modport source (output valid, output up_bin_count, output down_bin_count,
                    output up_run_total, output down_run_total, output up_length_sum,
                    output down_length_sum, output current_length, output current_rising,
                    input ready);
    modport sink   (input valid, input up_bin_count, input down_bin_count,
                    input up_run_total, input down_run_total, input up_length_sum,
                    input down_length_sum, input current_length, input current_rising,
                    output ready);
endinterface

[design/rudt_ram.sv]
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
module rudt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[design/rudt_front.sv]
// Front end: accepts transactions, tracks the run in progress and classifies each one.
`timescale 1ns / 1ps
module rudt_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rudt_in_if.sink          i_in,
    output logic             o_evt_valid,
    output rudt_pkg::t_event o_evt,
    input  logic             i_evt_ready
);

    rudt_pkg::t_sample r_last;
    rudt_pkg::t_sample n_last;
    logic              r_primed;
    logic              n_primed;
    logic              r_rising;
    logic              n_rising;
    rudt_pkg::t_bin    r_run_len;
    rudt_pkg::t_bin    n_run_len;
    rudt_pkg::t_sample sample;
    logic              accept;
    logic              is_push;
    logic              up;
    logic              close_valid;

    assign sample  = rudt_pkg::t_sample'(i_in.sample);
    assign accept  = i_in.valid && i_evt_ready;
    assign is_push = rudt_pkg::t_op'(i_in.operation) == rudt_pkg::OP_PUSH;
    assign up      = sample > r_last;

    always_comb begin
        n_last      = r_last;
        n_primed    = r_primed;
        n_rising    = r_rising;
        n_run_len   = r_run_len;
        close_valid = 1'b0;
        if (is_push) begin
            n_last = sample;
            if (!r_primed) begin
                n_primed = 1'b1;
            end else if (r_run_len == '0) begin
                n_rising  = up;
                n_run_len = rudt_pkg::t_bin'(1);
            end else if (up != r_rising) begin
                close_valid = 1'b1;
                n_rising    = up;
                n_run_len   = rudt_pkg::t_bin'(1);
            end else if (r_run_len < rudt_pkg::TOP_BIN) begin
                n_run_len = r_run_len + rudt_pkg::t_bin'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= '0;
            r_primed  <= 1'b0;
            r_rising  <= 1'b1;
            r_run_len <= '0;
        end else if (accept) begin
            r_last    <= n_last;
            r_primed  <= n_primed;
            r_rising  <= n_rising;
            r_run_len <= n_run_len;
        end
    end

    always_comb begin
        o_evt.close_valid = close_valid;
        o_evt.close_up    = r_rising;
        o_evt.close_len   = r_run_len;
        o_evt.report_ok   = 32'(i_in.bin_index) < 32'(rudt_pkg::MAX_RUN_BINS);
        o_evt.report_bin  = rudt_pkg::t_bin'(i_in.bin_index);
        o_evt.cur_len     = n_run_len;
        o_evt.cur_rising  = n_rising;
    end

    assign o_evt_valid = i_in.valid;
    assign i_in.ready  = i_evt_ready;

endmodule

[design/rudt_queue.sv]
// Short queue of classified transactions between the front end and the back end.
`timescale 1ns / 1ps
module rudt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    input  rudt_pkg::t_event i_push_evt,
    output logic             o_push_ready,
    output logic             o_pop_valid,
    output rudt_pkg::t_event o_pop_evt,
    input  logic             i_pop_ready
);

    rudt_pkg::t_event           r_mem [rudt_pkg::QUEUE_DEPTH];
    logic [rudt_pkg::QAW-1:0]   r_wr_ptr;
    logic [rudt_pkg::QAW-1:0]   r_rd_ptr;
    logic [rudt_pkg::QAW:0]     r_count;
    logic                       push;
    logic                       pop;

    assign o_push_ready = r_count != (rudt_pkg::QAW + 1)'(rudt_pkg::QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_evt    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + rudt_pkg::QAW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + rudt_pkg::QAW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + (rudt_pkg::QAW + 1)'(1);
            end else if (pop && !push) begin
                r_count <= r_count - (rudt_pkg::QAW + 1)'(1);
            end
        end
    end

endmodule

[design/rudt_back.sv]
// Back end: updates the histograms and totals and registers each result transaction.
`timescale 1ns / 1ps
module rudt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_evt_valid,
    input  rudt_pkg::t_event i_evt,
    output logic             o_evt_ready,
    rudt_out_if.source       o_out
);

    logic [rudt_pkg::MAX_RUN_BINS-1:0] r_up_vld;
    logic [rudt_pkg::MAX_RUN_BINS-1:0] r_dn_vld;

    logic               r_b1_valid;
    rudt_pkg::t_event   r_b1_evt;
    logic               r_b1_up_vld_a;
    logic               r_b1_up_vld_b;
    logic               r_b1_dn_vld_a;
    logic               r_b1_dn_vld_b;

    logic               r_fw_valid;
    logic               r_fw_up;
    rudt_pkg::t_bin     r_fw_addr;
    rudt_pkg::t_count   r_fw_data;

    rudt_pkg::t_count   r_up_runs;
    rudt_pkg::t_count   r_dn_runs;
    rudt_pkg::t_sum     r_up_sum;
    rudt_pkg::t_sum     r_dn_sum;

    logic               r_out_valid;
    rudt_pkg::t_count   r_out_up_bin;
    rudt_pkg::t_count   r_out_dn_bin;
    rudt_pkg::t_count   r_out_up_runs;
    rudt_pkg::t_count   r_out_dn_runs;
    rudt_pkg::t_sum     r_out_up_sum;
    rudt_pkg::t_sum     r_out_dn_sum;
    rudt_pkg::t_len_out r_out_len;
    logic               r_out_rising;

    rudt_pkg::t_count   n_up_runs;
    rudt_pkg::t_count   n_dn_runs;
    rudt_pkg::t_sum     n_up_sum;
    rudt_pkg::t_sum     n_dn_sum;

    rudt_pkg::t_count   up_rd_a;
    rudt_pkg::t_count   up_rd_b;
    rudt_pkg::t_count   dn_rd_a;
    rudt_pkg::t_count   dn_rd_b;
    rudt_pkg::t_count   up_a;
    rudt_pkg::t_count   up_b;
    rudt_pkg::t_count   dn_a;
    rudt_pkg::t_count   dn_b;
    rudt_pkg::t_count   new_val;
    rudt_pkg::t_count   rep_up;
    rudt_pkg::t_count   rep_dn;

    logic               out_free;
    logic               advance;
    logic               take;
    logic               fire;
    logic               upd_up;
    logic               upd_dn;
    logic               same_bin;

    assign out_free    = !r_out_valid || o_out.ready;
    assign advance     = !r_b1_valid || out_free;
    assign take        = i_evt_valid && advance;
    assign fire        = r_b1_valid && out_free;
    assign o_evt_ready = advance;

    assign upd_up   = r_b1_evt.close_valid && r_b1_evt.close_up;
    assign upd_dn   = r_b1_evt.close_valid && !r_b1_evt.close_up;
    assign same_bin = r_b1_evt.report_bin == r_b1_evt.close_len;

    rudt_ram #(
        .WIDTH (rudt_pkg::CNT_W),
        .DEPTH (rudt_pkg::MAX_RUN_BINS)
    ) u_up_ram (
        .i_clk     (i_clk),
        .i_we      (fire && upd_up),
        .i_waddr   (r_b1_evt.close_len),
        .i_wdata   (new_val),
        .i_re      (take),
        .i_raddr_a (i_evt.close_len),
        .i_raddr_b (i_evt.report_bin),
        .o_rdata_a (up_rd_a),
        .o_rdata_b (up_rd_b)
    );

    rudt_ram #(
        .WIDTH (rudt_pkg::CNT_W),
        .DEPTH (rudt_pkg::MAX_RUN_BINS)
    ) u_dn_ram (
        .i_clk     (i_clk),
        .i_we      (fire && upd_dn),
        .i_waddr   (r_b1_evt.close_len),
        .i_wdata   (new_val),
        .i_re      (take),
        .i_raddr_a (i_evt.close_len),
        .i_raddr_b (i_evt.report_bin),
        .o_rdata_a (dn_rd_a),
        .o_rdata_b (dn_rd_b)
    );

    // The latest histogram write always holds the current value of its bin.
    always_comb begin
        up_a = r_b1_up_vld_a ? up_rd_a : '0;
        up_b = r_b1_up_vld_b ? up_rd_b : '0;
        dn_a = r_b1_dn_vld_a ? dn_rd_a : '0;
        dn_b = r_b1_dn_vld_b ? dn_rd_b : '0;
        if (r_fw_valid && r_fw_up && r_fw_addr == r_b1_evt.close_len) begin
            up_a = r_fw_data;
        end
        if (r_fw_valid && r_fw_up && r_fw_addr == r_b1_evt.report_bin) begin
            up_b = r_fw_data;
        end
        if (r_fw_valid && !r_fw_up && r_fw_addr == r_b1_evt.close_len) begin
            dn_a = r_fw_data;
        end
        if (r_fw_valid && !r_fw_up && r_fw_addr == r_b1_evt.report_bin) begin
            dn_b = r_fw_data;
        end
    end

    always_comb begin
        new_val   = rudt_pkg::sat_inc_count(r_b1_evt.close_up ? up_a : dn_a);
        rep_up    = (upd_up && same_bin) ? new_val : up_b;
        rep_dn    = (upd_dn && same_bin) ? new_val : dn_b;
        n_up_runs = upd_up ? rudt_pkg::sat_inc_count(r_up_runs) : r_up_runs;
        n_dn_runs = upd_dn ? rudt_pkg::sat_inc_count(r_dn_runs) : r_dn_runs;
        n_up_sum  = upd_up ? rudt_pkg::sat_add_sum(r_up_sum, r_b1_evt.close_len) : r_up_sum;
        n_dn_sum  = upd_dn ? rudt_pkg::sat_add_sum(r_dn_sum, r_b1_evt.close_len) : r_dn_sum;
        if (!r_b1_evt.report_ok) begin
            rep_up = '0;
            rep_dn = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_b1_evt      <= i_evt;
            r_b1_up_vld_a <= r_up_vld[i_evt.close_len];
            r_b1_up_vld_b <= r_up_vld[i_evt.report_bin];
            r_b1_dn_vld_a <= r_dn_vld[i_evt.close_len];
            r_b1_dn_vld_b <= r_dn_vld[i_evt.report_bin];
        end
        if (fire && r_b1_evt.close_valid) begin
            r_fw_up   <= r_b1_evt.close_up;
            r_fw_addr <= r_b1_evt.close_len;
            r_fw_data <= new_val;
        end
        if (fire) begin
            r_out_up_bin  <= rep_up;
            r_out_dn_bin  <= rep_dn;
            r_out_up_runs <= n_up_runs;
            r_out_dn_runs <= n_dn_runs;
            r_out_up_sum  <= n_up_sum;
            r_out_dn_sum  <= n_dn_sum;
            r_out_len     <= rudt_pkg::t_len_out'(r_b1_evt.cur_len);
            r_out_rising  <= r_b1_evt.cur_rising;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_fw_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_up_vld    <= '0;
            r_dn_vld    <= '0;
            r_up_runs   <= '0;
            r_dn_runs   <= '0;
            r_up_sum    <= '0;
            r_dn_sum    <= '0;
        end else begin
            if (advance) begin
                r_b1_valid <= i_evt_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
                r_up_runs   <= n_up_runs;
                r_dn_runs   <= n_dn_runs;
                r_up_sum    <= n_up_sum;
                r_dn_sum    <= n_dn_sum;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (fire && r_b1_evt.close_valid) begin
                r_fw_valid <= 1'b1;
            end
            if (fire && upd_up) begin
                r_up_vld[r_b1_evt.close_len] <= 1'b1;
            end
            if (fire && upd_dn) begin
                r_dn_vld[r_b1_evt.close_len] <= 1'b1;
            end
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.up_bin_count    = r_out_up_bin;
    assign o_out.down_bin_count  = r_out_dn_bin;
    assign o_out.up_run_total    = r_out_up_runs;
    assign o_out.down_run_total  = r_out_dn_runs;
    assign o_out.up_length_sum   = r_out_up_sum;
    assign o_out.down_length_sum = r_out_dn_sum;
    assign o_out.current_length  = r_out_len;
    assign o_out.current_rising  = r_out_rising;

endmodule

[design/runs_up_down_tally_top.sv]
// Top level of the runs up and down tally.
//
// Each input transaction either pushes a sample (operation 0) or only reads
// (operation 1), and every transaction returns exactly one result with the
// two histogram bins selected by bin_index and all run totals, as they stand
// after that transaction. One transaction is accepted per clock cycle,
// sustained, while the output side is not stalled, and a result passes
// through the queue, the back-end stage register and the output register.
// The rate is set by the compare of the new sample against the previous
// one in the front end, and by the read-increment-write of a histogram bin
// in the back end, whose latest write is forwarded to the next transaction.
// A four-entry queue between the two halves absorbs output stalls. The
// histograms are cleared at reset through one valid flag per bin, so
// transactions are taken from the first cycle after reset.
`timescale 1ns / 1ps
module runs_up_down_tally_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rudt_in_if.sink    i_in,
    rudt_out_if.source o_out
);

    logic             front_valid;
    rudt_pkg::t_event front_evt;
    logic             front_ready;
    logic             back_valid;
    rudt_pkg::t_event back_evt;
    logic             back_ready;

    rudt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_evt_valid (front_valid),
        .o_evt       (front_evt),
        .i_evt_ready (front_ready)
    );

    rudt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_evt   (front_evt),
        .o_push_ready (front_ready),
        .o_pop_valid  (back_valid),
        .o_pop_evt    (back_evt),
        .i_pop_ready  (back_ready)
    );

    rudt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (back_valid),
        .i_evt       (back_evt),
        .o_evt_ready (back_ready),
        .o_out       (o_out)
    );

endmodule

[design/rudt_chk.sv]
// Checker on the ports of the runs tally top level, with its bind statement.
`timescale 1ns / 1ps
`include "runs_up_down_tally_top_defines.svh"

module rudt_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input rudt_pkg::t_count   i_up_bin,
    input rudt_pkg::t_count   i_dn_bin,
    input rudt_pkg::t_count   i_up_runs,
    input rudt_pkg::t_count   i_dn_runs,
    input rudt_pkg::t_sum     i_up_sum,
    input rudt_pkg::t_sum     i_dn_sum,
    input rudt_pkg::t_len_out i_cur_len
);

    `RUDT_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_up_runs) && $stable(i_dn_sum))
    `RUDT_ASSERT_NOW(a_bin_le_total, i_out_valid, (i_up_bin <= i_up_runs) && (i_dn_bin <= i_dn_runs))
    `RUDT_ASSERT_NOW(a_sum_ge_runs, i_out_valid, (rudt_pkg::t_sum'(i_up_runs) <= i_up_sum) && (rudt_pkg::t_sum'(i_dn_runs) <= i_dn_sum))
    `RUDT_ASSERT_NEXT(a_totals_grow, i_out_valid && i_out_ready, !i_out_valid || ((i_up_runs >= $past(i_up_runs)) && (i_dn_sum >= $past(i_dn_sum))))
    `RUDT_ASSERT_NOW(a_len_range, i_out_valid, 32'(i_cur_len) < 32'(rudt_pkg::MAX_RUN_BINS))

endmodule

bind runs_up_down_tally_top rudt_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_up_bin    (o_out.up_bin_count),
    .i_dn_bin    (o_out.down_bin_count),
    .i_up_runs   (o_out.up_run_total),
    .i_dn_runs   (o_out.down_run_total),
    .i_up_sum    (o_out.up_length_sum),
    .i_dn_sum    (o_out.down_length_sum),
    .i_cur_len   (o_out.current_length)
);
